// ----- rtl/fba_pkg.sv -----
// ---------------------------------------------------------------------------
// fba_pkg
// Shared constants, command codes, status group and link helpers for the
// first-fit heap allocator.
// ---------------------------------------------------------------------------
package fba_pkg;

   // heap geometry
   localparam int HEAP_WORDS = 1024;
   localparam int WORD_BITS  = 32;
   localparam int ADDR_W     = $clog2(HEAP_WORDS);
   localparam int XW         = ADDR_W + 2;
   localparam int STEP_W     = ADDR_W + 1;

   // item field widths
   localparam int SIZE_W  = 10;
   localparam int TAG_W   = 16;
   localparam int OBJ_W   = 10;
   localparam int BADDR_W = 10;
   localparam int STAT_W  = 2;

   localparam logic [WORD_BITS-1:0] LINK_END = '1;
   localparam logic [XW-1:0]        MAX_NODE = XW'(HEAP_WORDS - 2);
   localparam logic [XW-1:0]        HDR      = XW'(2);

   // result status codes
   localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
   localparam logic [STAT_W-1:0] ST_OOM = 2'd1;
   localparam logic [STAT_W-1:0] ST_BAD = 2'd2;

   // operation select
   localparam logic FUNC_ALLOC = 1'b0;

   typedef enum logic [4:0] {
      CMD_NOP,
      CMD_INIT,
      CMD_LOAD,
      CMD_A_START,
      CMD_RD_CUR,
      CMD_CAP_SZ_RD_LINK,
      CMD_CAP_NX,
      CMD_ADVANCE,
      CMD_SPLIT_SZ,
      CMD_SPLIT_LNK,
      CMD_SPLIT_HDR,
      CMD_UNLINK,
      CMD_CLEAR,
      CMD_TAG,
      CMD_OOM,
      CMD_F_START,
      CMD_F_CAP_SZ,
      CMD_RD_LINK,
      CMD_WALK_STEP,
      CMD_RD_PREV,
      CMD_BAD,
      CMD_LINK_NEW,
      CMD_LINK_PREV,
      CMD_M_START,
      CMD_M_CAP_NX,
      CMD_M_CAP_SZ,
      CMD_M_ADVANCE,
      CMD_M_WSZ,
      CMD_M_WLNK,
      CMD_OK,
      CMD_PUBLISH
   } cmd_type;

   typedef struct packed {
      logic func;
      logic init_last;
      logic cur_none;
      logic prev_none;
      logic nx_none;
      logic steps_max;
      logic fit;
      logic split;
      logic clear_go;
      logic low;
      logic fit_bad;
      logic walk_go;
      logic hit;
      logic over;
      logic prev_bad;
      logic adj;
   } status_type;

   // a link word that is the end mark or points past the last node ends the list
   function automatic logic link_none(input logic [WORD_BITS-1:0] v);
      return (v == LINK_END) || (v > WORD_BITS'(HEAP_WORDS - 2));
   endfunction

   function automatic logic [WORD_BITS-1:0] link_word(input logic none,
                                                      input logic [XW-1:0] node);
      return none ? LINK_END : WORD_BITS'(node);
   endfunction

endpackage

// ----- rtl/first_fit_heap_allocator.sv -----
// ---------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap manager over an address-ordered free list held in a word
// memory, with block split on allocate and neighbor merge on free.
// ---------------------------------------------------------------------------
//  channel | ports                    | contents
//  --------+--------------------------+--------------------------------------
//  request | req_tvalid/tready/tuser/ | tuser: func; tdata: req_size,
//          | tdata                    | meta_tag, obj_addr
//  result  | rsp_tvalid/tready/tdata  | tdata: block_addr, status
//
//  After reset a clearing pass writes all 1024 heap words while req_tready
//  stays low.
//  An allocate loads and dispatches the request, walks the free blocks in
//  order, splits the block it takes where the rest is large enough, unlinks
//  it, clears its data words, writes the tag and hands over the result; a
//  free checks the header, walks the free blocks below it, links the block in
//  and makes a merge pass over the list. The heap memory has one write port
//  and one registered read port. A result waits in the output register; the
//  next request is taken meanwhile and holds in its last step until the previous result transfer is done.
// ---------------------------------------------------------------------------
module first_fit_heap_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [0:0]  req_tuser,   // func
   input  logic [39:0] req_tdata,   // req_size, meta_tag, obj_addr, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // block_addr, status, zero fill
);
   import fba_pkg::*;

   cmd_type              cmd;
   status_type           stat;
   logic [BADDR_W-1:0]   out_addr;
   logic [STAT_W-1:0]    out_stat;

   fba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .cmd       (cmd)
   );

   fba_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .in_func  (req_tuser[0]),
      .in_size  (req_tdata[9:0]),
      .in_tag   (req_tdata[25:10]),
      .in_obj   (req_tdata[35:26]),
      .stat     (stat),
      .out_addr (out_addr),
      .out_stat (out_stat)
   );

   assign rsp_tdata = {4'b0, out_stat, out_addr};

`ifndef SYNTH
   // an accepted request drops req_tready, so requests are never taken back to back
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken twice in a row");

   // only the three defined status codes leave the block
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[11:10] <= ST_BAD)
      else $error("undefined status code");

   // failed requests and frees carry a zero address
   a_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[11:10] != ST_OK |-> rsp_tdata[9:0] == 10'd0)
      else $error("nonzero address on failure");

   // a new result is only loaded when the output register is free
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("pending result overwritten");
`endif

endmodule

// ----- rtl/fba_datapath.sv -----
// ---------------------------------------------------------------------------
// fba_datapath
// Heap word memory, list walk registers, request and result registers.
// Carries out one command per cycle and reports status flags.
// ---------------------------------------------------------------------------
module fba_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  fba_pkg::cmd_type               cmd,
   input  logic                           in_func,
   input  logic [fba_pkg::SIZE_W-1:0]     in_size,
   input  logic [fba_pkg::TAG_W-1:0]      in_tag,
   input  logic [fba_pkg::OBJ_W-1:0]      in_obj,
   output fba_pkg::status_type            stat,
   output logic [fba_pkg::BADDR_W-1:0]    out_addr,
   output logic [fba_pkg::STAT_W-1:0]     out_stat
);
   import fba_pkg::*;

   logic [WORD_BITS-1:0] mem [HEAP_WORDS];
   logic [WORD_BITS-1:0] rdata_ff;

   logic [XW-1:0]        cur_ff, cur_in, prev_ff, prev_in, nx_ff, nx_in, n_ff, n_in;
   logic                 cur_none_ff, cur_none_in, prev_none_ff, prev_none_in;
   logic                 nx_none_ff, nx_none_in;
   logic [WORD_BITS-1:0] sz_ff, sz_in;
   logic [STEP_W-1:0]    steps_ff, steps_in;
   logic [XW-1:0]        idx_ff, idx_in, cnt_ff, cnt_in;
   logic [ADDR_W-1:0]    head_ff, head_in;
   logic                 empty_ff, empty_in;
   logic                 func_ff, func_in, low_ff, low_in;
   logic [SIZE_W-1:0]    size_ff, size_in;
   logic [TAG_W-1:0]     tag_ff, tag_in;
   logic [OBJ_W-1:0]     obj_ff, obj_in;
   logic [BADDR_W-1:0]   res_addr_ff, res_addr_in, out_addr_ff, out_addr_in;
   logic [STAT_W-1:0]    res_stat_ff, res_stat_in, out_stat_ff, out_stat_in;

   logic                 wr_en;
   logic [XW-1:0]        wr_addr, rd_addr, nn, pdist;
   logic [WORD_BITS-1:0] wr_data, szreq;

   assign nn    = cur_ff + HDR + XW'(size_ff);
   assign szreq = sz_ff - WORD_BITS'(size_ff);
   assign pdist = n_ff - prev_ff;

   // status flags for the controller
   always_comb begin
      stat.func      = func_ff;
      stat.init_last = idx_ff[ADDR_W-1:0] == ADDR_W'(HEAP_WORDS - 1);
      stat.cur_none  = cur_none_ff;
      stat.prev_none = prev_none_ff;
      stat.nx_none   = nx_none_ff;
      stat.steps_max = steps_ff == STEP_W'(HEAP_WORDS);
      stat.fit       = sz_ff >= WORD_BITS'(size_ff);
      stat.split     = szreq >= WORD_BITS'(4);
      stat.clear_go  = (WORD_BITS'(cnt_ff) < sz_ff) && (idx_ff < XW'(HEAP_WORDS));
      stat.low       = low_ff;
      stat.fit_bad   = sz_ff > WORD_BITS'(MAX_NODE - n_ff);
      stat.walk_go   = !cur_none_ff && (cur_ff < n_ff) && (steps_ff != STEP_W'(HEAP_WORDS));
      stat.hit       = !cur_none_ff && (cur_ff == n_ff);
      stat.over      = !cur_none_ff &&
                       ((WORD_BITS'(n_ff) + WORD_BITS'(HDR) + sz_ff) > WORD_BITS'(cur_ff));
      stat.prev_bad  = (pdist < HDR) || (rdata_ff > WORD_BITS'(pdist - HDR));
      stat.adj       = ((WORD_BITS + 1)'(cur_ff) + (WORD_BITS + 1)'(HDR) +
                        (WORD_BITS + 1)'(sz_ff)) == (WORD_BITS + 1)'(nx_ff);
   end

   // command decode
   always_comb begin
      cur_in       = cur_ff;
      cur_none_in  = cur_none_ff;
      prev_in      = prev_ff;
      prev_none_in = prev_none_ff;
      nx_in        = nx_ff;
      nx_none_in   = nx_none_ff;
      n_in         = n_ff;
      sz_in        = sz_ff;
      steps_in     = steps_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      head_in      = head_ff;
      empty_in     = empty_ff;
      func_in      = func_ff;
      low_in       = low_ff;
      size_in      = size_ff;
      tag_in       = tag_ff;
      obj_in       = obj_ff;
      res_addr_in  = res_addr_ff;
      res_stat_in  = res_stat_ff;
      out_addr_in  = out_addr_ff;
      out_stat_in  = out_stat_ff;
      wr_en        = 1'b0;
      wr_addr      = cur_ff;
      wr_data      = '0;
      rd_addr      = cur_ff;
      unique case (cmd)
         CMD_INIT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            if (idx_ff == XW'(0)) wr_data = WORD_BITS'(HEAP_WORDS - 2);
            else if (idx_ff == XW'(1)) wr_data = LINK_END;
            idx_in  = idx_ff + XW'(1);
         end
         CMD_LOAD: begin
            func_in = in_func;
            size_in = in_size;
            tag_in  = in_tag;
            obj_in  = in_obj;
         end
         CMD_A_START, CMD_F_START: begin
            cur_in       = XW'(head_ff);
            cur_none_in  = empty_ff;
            prev_none_in = 1'b1;
            steps_in     = '0;
            n_in         = XW'(obj_ff) - HDR;
            low_in       = XW'(obj_ff) < HDR;
            rd_addr      = XW'(obj_ff) - HDR;
         end
         CMD_RD_CUR: rd_addr = cur_ff;
         CMD_CAP_SZ_RD_LINK: begin
            sz_in   = rdata_ff;
            rd_addr = cur_ff + XW'(1);
         end
         CMD_CAP_NX, CMD_M_CAP_NX: begin
            nx_none_in = link_none(rdata_ff);
            nx_in      = rdata_ff[XW-1:0];
            rd_addr    = cur_ff;
         end
         CMD_ADVANCE: begin
            prev_in      = cur_ff;
            prev_none_in = 1'b0;
            cur_in       = nx_ff;
            cur_none_in  = nx_none_ff;
            steps_in     = steps_ff + STEP_W'(1);
         end
         CMD_SPLIT_SZ: begin
            wr_en   = 1'b1;
            wr_addr = nn;
            wr_data = szreq - WORD_BITS'(HDR);
         end
         CMD_SPLIT_LNK: begin
            wr_en   = 1'b1;
            wr_addr = nn + XW'(1);
            wr_data = link_word(nx_none_ff, nx_ff);
         end
         CMD_SPLIT_HDR: begin
            wr_en      = 1'b1;
            wr_addr    = cur_ff;
            wr_data    = WORD_BITS'(size_ff);
            sz_in      = WORD_BITS'(size_ff);
            nx_in      = nn;
            nx_none_in = 1'b0;
         end
         CMD_UNLINK: begin
            idx_in = cur_ff + HDR;
            cnt_in = '0;
            if (prev_none_ff) begin
               empty_in = nx_none_ff;
               head_in  = nx_none_ff ? '0 : nx_ff[ADDR_W-1:0];
            end else begin
               wr_en   = 1'b1;
               wr_addr = prev_ff + XW'(1);
               wr_data = link_word(nx_none_ff, nx_ff);
            end
         end
         CMD_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = LINK_END;
            idx_in  = idx_ff + XW'(1);
            cnt_in  = cnt_ff + XW'(1);
         end
         CMD_TAG: begin
            wr_en       = 1'b1;
            wr_addr     = cur_ff + XW'(1);
            wr_data     = WORD_BITS'(tag_ff);
            res_addr_in = BADDR_W'(cur_ff + HDR);
            res_stat_in = ST_OK;
         end
         CMD_OOM: begin
            res_addr_in = '0;
            res_stat_in = ST_OOM;
         end
         CMD_F_CAP_SZ: sz_in = rdata_ff;
         CMD_RD_LINK: rd_addr = cur_ff + XW'(1);
         CMD_WALK_STEP: begin
            prev_in      = cur_ff;
            prev_none_in = 1'b0;
            cur_none_in  = link_none(rdata_ff);
            cur_in       = rdata_ff[XW-1:0];
            steps_in     = steps_ff + STEP_W'(1);
         end
         CMD_RD_PREV: rd_addr = prev_ff;
         CMD_BAD: begin
            res_addr_in = '0;
            res_stat_in = ST_BAD;
         end
         CMD_LINK_NEW: begin
            wr_en   = 1'b1;
            wr_addr = n_ff + XW'(1);
            wr_data = link_word(cur_none_ff, cur_ff);
         end
         CMD_LINK_PREV: begin
            if (prev_none_ff) begin
               head_in  = n_ff[ADDR_W-1:0];
               empty_in = 1'b0;
            end else begin
               wr_en   = 1'b1;
               wr_addr = prev_ff + XW'(1);
               wr_data = WORD_BITS'(n_ff);
            end
         end
         CMD_M_START: begin
            cur_in      = XW'(head_ff);
            cur_none_in = 1'b0;
            steps_in    = '0;
         end
         CMD_M_CAP_SZ: begin
            sz_in   = rdata_ff;
            rd_addr = nx_ff;
         end
         CMD_M_ADVANCE: begin
            cur_in   = nx_ff;
            steps_in = steps_ff + STEP_W'(1);
         end
         CMD_M_WSZ: begin
            wr_en   = 1'b1;
            wr_addr = cur_ff;
            wr_data = sz_ff + rdata_ff + WORD_BITS'(HDR);
            rd_addr = nx_ff + XW'(1);
         end
         CMD_M_WLNK: begin
            wr_en    = 1'b1;
            wr_addr  = cur_ff + XW'(1);
            wr_data  = rdata_ff;
            steps_in = steps_ff + STEP_W'(1);
         end
         CMD_OK: begin
            res_addr_in = '0;
            res_stat_in = ST_OK;
         end
         CMD_PUBLISH: begin
            out_addr_in = res_addr_ff;
            out_stat_in = res_stat_ff;
         end
         default: ;
      endcase
   end

   // heap memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr < XW'(HEAP_WORDS))) begin
         mem[wr_addr[ADDR_W-1:0]] <= wr_data;
      end
      rdata_ff <= mem[rd_addr[ADDR_W-1:0]];
   end

   // list head and clearing pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         empty_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         head_ff  <= head_in;
         empty_ff <= empty_in;
         idx_ff   <= idx_in;
      end
   end

   // walk and request payload registers
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      cur_none_ff  <= cur_none_in;
      prev_ff      <= prev_in;
      prev_none_ff <= prev_none_in;
      nx_ff        <= nx_in;
      nx_none_ff   <= nx_none_in;
      n_ff         <= n_in;
      sz_ff        <= sz_in;
      steps_ff     <= steps_in;
      cnt_ff       <= cnt_in;
      func_ff      <= func_in;
      low_ff       <= low_in;
      size_ff      <= size_in;
      tag_ff       <= tag_in;
      obj_ff       <= obj_in;
      res_addr_ff  <= res_addr_in;
      res_stat_ff  <= res_stat_in;
      out_addr_ff  <= out_addr_in;
      out_stat_ff  <= out_stat_in;
   end

   assign out_addr = out_addr_ff;
   assign out_stat = out_stat_ff;

endmodule

// ----- rtl/fba_ctrl.sv -----
// ---------------------------------------------------------------------------
// fba_ctrl
// Sequencer for the allocator: clearing pass, allocate walk, free walk and
// merge loop, result hand-off.
// ---------------------------------------------------------------------------
module fba_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  fba_pkg::status_type  stat,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output fba_pkg::cmd_type     cmd
);
   import fba_pkg::*;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_DISP,
      S_A_CHK, S_A_SZ, S_A_NX, S_A_TEST, S_A_SPL1, S_A_SPL2, S_A_SPL3,
      S_A_UNL, S_A_CLR,
      S_F_SZ, S_F_FIT, S_F_WALK, S_F_STEP, S_F_CHK, S_F_PCHK, S_F_LNK1, S_F_LNK2,
      S_M_START, S_M_CHK, S_M_NX, S_M_SZ, S_M_TEST, S_M_LNK,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and command
   always_comb begin
      state_in     = state_ff;
      cmd          = CMD_NOP;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_INIT: begin
            cmd = CMD_INIT;
            if (stat.init_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (stat.func == FUNC_ALLOC) begin
               cmd      = CMD_A_START;
               state_in = S_A_CHK;
            end else begin
               cmd      = CMD_F_START;
               state_in = S_F_SZ;
            end
         end
         // allocate: first fit walk
         S_A_CHK: begin
            if (stat.cur_none || stat.steps_max) begin
               cmd      = CMD_OOM;
               state_in = S_DONE;
            end else begin
               cmd      = CMD_RD_CUR;
               state_in = S_A_SZ;
            end
         end
         S_A_SZ: begin
            cmd      = CMD_CAP_SZ_RD_LINK;
            state_in = S_A_NX;
         end
         S_A_NX: begin
            cmd      = CMD_CAP_NX;
            state_in = S_A_TEST;
         end
         S_A_TEST: begin
            if (!stat.fit) begin
               cmd      = CMD_ADVANCE;
               state_in = S_A_CHK;
            end else if (stat.split) begin
               state_in = S_A_SPL1;
            end else begin
               state_in = S_A_UNL;
            end
         end
         S_A_SPL1: begin
            cmd      = CMD_SPLIT_SZ;
            state_in = S_A_SPL2;
         end
         S_A_SPL2: begin
            cmd      = CMD_SPLIT_LNK;
            state_in = S_A_SPL3;
         end
         S_A_SPL3: begin
            cmd      = CMD_SPLIT_HDR;
            state_in = S_A_UNL;
         end
         S_A_UNL: begin
            cmd      = CMD_UNLINK;
            state_in = S_A_CLR;
         end
         S_A_CLR: begin
            if (stat.clear_go) begin
               cmd = CMD_CLEAR;
            end else begin
               cmd      = CMD_TAG;
               state_in = S_DONE;
            end
         end
         // free: header checks and ordered insert
         S_F_SZ: begin
            if (stat.low) begin
               cmd      = CMD_BAD;
               state_in = S_DONE;
            end else begin
               cmd      = CMD_F_CAP_SZ;
               state_in = S_F_FIT;
            end
         end
         S_F_FIT: begin
            if (stat.fit_bad) begin
               cmd      = CMD_BAD;
               state_in = S_DONE;
            end else begin
               state_in = S_F_WALK;
            end
         end
         S_F_WALK: begin
            if (stat.walk_go) begin
               cmd      = CMD_RD_LINK;
               state_in = S_F_STEP;
            end else begin
               state_in = S_F_CHK;
            end
         end
         S_F_STEP: begin
            cmd      = CMD_WALK_STEP;
            state_in = S_F_WALK;
         end
         S_F_CHK: begin
            if (stat.hit || stat.over) begin
               cmd      = CMD_BAD;
               state_in = S_DONE;
            end else if (stat.prev_none) begin
               state_in = S_F_LNK1;
            end else begin
               cmd      = CMD_RD_PREV;
               state_in = S_F_PCHK;
            end
         end
         S_F_PCHK: begin
            if (stat.prev_bad) begin
               cmd      = CMD_BAD;
               state_in = S_DONE;
            end else begin
               state_in = S_F_LNK1;
            end
         end
         S_F_LNK1: begin
            cmd      = CMD_LINK_NEW;
            state_in = S_F_LNK2;
         end
         S_F_LNK2: begin
            cmd      = CMD_LINK_PREV;
            state_in = S_M_START;
         end
         // free: merge pass over the whole list
         S_M_START: begin
            cmd      = CMD_M_START;
            state_in = S_M_CHK;
         end
         S_M_CHK: begin
            if (stat.steps_max) begin
               cmd      = CMD_OK;
               state_in = S_DONE;
            end else begin
               cmd      = CMD_RD_LINK;
               state_in = S_M_NX;
            end
         end
         S_M_NX: begin
            cmd      = CMD_M_CAP_NX;
            state_in = S_M_SZ;
         end
         S_M_SZ: begin
            if (stat.nx_none) begin
               cmd      = CMD_OK;
               state_in = S_DONE;
            end else begin
               cmd      = CMD_M_CAP_SZ;
               state_in = S_M_TEST;
            end
         end
         S_M_TEST: begin
            if (stat.adj) begin
               cmd      = CMD_M_WSZ;
               state_in = S_M_LNK;
            end else begin
               cmd      = CMD_M_ADVANCE;
               state_in = S_M_CHK;
            end
         end
         S_M_LNK: begin
            cmd      = CMD_M_WLNK;
            state_in = S_M_CHK;
         end
         // hand the result to the output register
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd          = CMD_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- tb/first_fit_heap_allocator_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_checker
// Watches the request and result channels, keeps a private model of the heap
// and free list, and compares every result transfer with its prediction.
// ---------------------------------------------------------------------------
module first_fit_heap_allocator_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [0:0]  req_tuser,
   input  logic [39:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   output int          fail_count,
   output int          pending_count
);
   import fba_pkg::*;

   typedef struct packed {
      logic [BADDR_W-1:0] block_addr;
      logic [STAT_W-1:0]  status;
   } alloc_result_type;

   localparam longint NONE = -1;
   localparam longint HW   = HEAP_WORDS;

   logic [WORD_BITS-1:0] heap_mem [HEAP_WORDS];
   longint               head_node;
   bit                   heap_full;
   alloc_result_type     result_fifo [$];

   function automatic longint mem_rd(longint a);
      return (a >= 0 && a < HW) ? longint'(heap_mem[a]) : 0;
   endfunction

   function automatic void mem_wr(longint a, longint v);
      if (a >= 0 && a < HW) heap_mem[a] = v[WORD_BITS-1:0];
   endfunction

   function automatic longint next_of(longint n);
      longint v;
      v = mem_rd(n + 1);
      if (v == longint'(LINK_END) || v > HW - 2) return NONE;
      return v;
   endfunction

   function automatic longint link_val(longint n);
      return (n == NONE) ? longint'(LINK_END) : n;
   endfunction

   // first-fit allocation with split and clear
   function automatic alloc_result_type model_alloc(longint want, longint tag);
      alloc_result_type r;
      longint prev, cur, sz, nx, nn;
      prev = NONE;
      cur  = heap_full ? NONE : head_node;
      for (int steps = 0; cur != NONE && steps < HEAP_WORDS; steps++) begin
         sz = mem_rd(cur);
         nx = next_of(cur);
         if (sz >= want) begin
            if (sz - want >= 4) begin
               nn = cur + 2 + want;
               mem_wr(nn, sz - want - 2);
               mem_wr(nn + 1, link_val(nx));
               mem_wr(cur, want);
               sz = want;
               nx = nn;
            end
            if (prev == NONE) begin
               if (nx == NONE) begin
                  heap_full = 1;
                  head_node = 0;
               end else head_node = nx;
            end else mem_wr(prev + 1, link_val(nx));
            for (longint i = 0; i < sz && cur + 2 + i < HW; i++)
               mem_wr(cur + 2 + i, longint'(LINK_END));
            mem_wr(cur + 1, tag);
            r.block_addr = BADDR_W'(cur + 2);
            r.status     = ST_OK;
            return r;
         end
         prev = cur;
         cur  = nx;
      end
      r.block_addr = '0;
      r.status     = ST_OOM;
      return r;
   endfunction

   // address-ordered insert followed by a full merge pass
   function automatic logic [STAT_W-1:0] model_free(longint obj);
      longint n, sz, prev, cur, nx;
      if (obj < 2) return ST_BAD;
      n = obj - 2;
      if (n > HW - 2) return ST_BAD;
      sz = mem_rd(n);
      if (sz > HW - 2 - n) return ST_BAD;
      prev = NONE;
      cur  = heap_full ? NONE : head_node;
      for (int steps = 0; cur != NONE && cur < n && steps < HEAP_WORDS; steps++) begin
         prev = cur;
         cur  = next_of(cur);
      end
      if (cur == n) return ST_BAD;
      if (prev != NONE && (n - prev < 2 || mem_rd(prev) > n - prev - 2)) return ST_BAD;
      if (cur != NONE && n + 2 + sz > cur) return ST_BAD;
      mem_wr(n + 1, link_val(cur));
      if (prev == NONE) begin
         head_node = n;
         heap_full = 0;
      end else mem_wr(prev + 1, n);
      cur = head_node;
      for (int steps = 0; steps < HEAP_WORDS; steps++) begin
         nx = next_of(cur);
         if (nx == NONE) break;
         if (cur + 2 + mem_rd(cur) == nx) begin
            mem_wr(cur, mem_rd(cur) + mem_rd(nx) + 2);
            mem_wr(cur + 1, mem_rd(nx + 1));
         end else cur = nx;
      end
      return ST_OK;
   endfunction

   assign pending_count = result_fifo.size();

   always @(posedge clock) begin
      alloc_result_type exp_r, got_r;
      if (reset) begin
         foreach (heap_mem[i]) heap_mem[i] = '0;
         heap_mem[0] = WORD_BITS'(HEAP_WORDS - 2);
         heap_mem[1] = LINK_END;
         head_node   = 0;
         heap_full   = 0;
         result_fifo.delete();
         fail_count  = 0;
      end else begin
         // result transfer
         if (rsp_tvalid && rsp_tready) begin
            got_r = alloc_result_type'({rsp_tdata[9:0], rsp_tdata[11:10]});
            if (result_fifo.size() == 0) begin
               $error("unexpected result transfer %h", rsp_tdata);
               fail_count++;
            end else begin
               exp_r = result_fifo.pop_front();
               if (got_r.block_addr !== exp_r.block_addr) begin
                  $error("block_addr expected %0d actual %0d", exp_r.block_addr,
                         got_r.block_addr);
                  fail_count++;
               end
               if (got_r.status !== exp_r.status) begin
                  $error("status expected %0d actual %0d", exp_r.status, got_r.status);
                  fail_count++;
               end
            end
         end
         // request transfer
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == FUNC_ALLOC)
               exp_r = model_alloc(longint'(req_tdata[9:0]), longint'(req_tdata[25:10]));
            else begin
               exp_r.block_addr = '0;
               exp_r.status     = model_free(longint'(req_tdata[35:26]));
            end
            result_fifo.push_back(exp_r);
         end
      end
   end

endmodule

// ----- tb/first_fit_heap_allocator_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// Drives allocate and free requests with random gaps and result stalls; the
// checker predicts every result and counts mismatches.
// ---------------------------------------------------------------------------
module first_fit_heap_allocator_tb;
   import fba_pkg::*;

   localparam int STALL_LIMIT = 200000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [0:0]  req_tuser = '0;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;
   int          fail_count;
   int          pending_count;
   int          send_idle_pct = 23;
   int          recv_idle_pct = 60;
   int          idle_cycles = 0;
   logic [9:0]  live_addrs [$];

   always #2 clock = ~clock;

   first_fit_heap_allocator DUT (.*);

   first_fit_heap_allocator_checker u_checker (.*);

   // receiver stalls
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // capture allocated addresses for later frees
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready && rsp_tdata[11:10] == ST_OK
          && rsp_tdata[9:0] != 0)
         live_addrs.push_back(rsp_tdata[9:0]);

   // watchdog on transfer activity
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // valid drops only on an idle cycle, so back-to-back transfers keep it high
   task automatic send_req(bit func, int sz, int tag, int obj);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= func;
      req_tdata  <= {4'b0, obj[9:0], tag[15:0], sz[9:0]};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_random();
      int pick, idx;
      pick = $urandom_range(99);
      if (pick < 45)
         send_req(0, ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(40),
                  $urandom, $urandom);
      else if (pick < 85 && live_addrs.size() > 0) begin
         idx = $urandom_range(live_addrs.size() - 1);
         send_req(1, $urandom, $urandom, live_addrs[idx]);
         live_addrs.delete(idx);
      end else
         send_req($urandom_range(1), $urandom, $urandom, $urandom);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      // directed: extremes, split and exact fits, bad frees, merges
      send_req(0, 0, 16'h0000, 0);
      send_req(0, 1, 16'hFFFF, 0);
      send_req(0, 2, 16'h1234, 0);
      send_req(0, 1022, 16'hA5A5, 0);
      send_req(0, 1023, 16'h5A5A, 0);
      send_req(1, 0, 0, 0);
      send_req(1, 0, 0, 1);
      send_req(1, 0, 0, 1023);
      send_req(1, 0, 0, 2);
      send_req(1, 0, 0, 2);
      send_req(1, 0, 0, 4);
      send_req(1, 0, 0, 7);
      send_req(0, 1000, 16'h0F0F, 0);
      send_req(0, 3, 16'h00FF, 0);
      send_req(1, 1023, 16'hFFFF, 7);
      send_req(0, 1022, 16'h1111, 0);
      send_req(1, 0, 0, 1020);
      send_req(1, 0, 0, 2);
      send_req(0, 1022, 16'h2222, 0);
      send_req(1, 0, 0, 2);
      send_req(0, 1022, 16'h3333, 0);
      req_tvalid <= 0;
      wait (pending_count == 0);
      repeat (1200) @(posedge clock);
      // random phases with changing idle mix
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 60 : 0;
         recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 23 : 0;
         repeat (210) send_random();
      end
      req_tvalid <= 0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (1200) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ----- first_fit_heap_allocator.f -----
rtl/fba_pkg.sv
rtl/fba_datapath.sv
rtl/fba_ctrl.sv
rtl/first_fit_heap_allocator.sv
tb/first_fit_heap_allocator_checker.sv
tb/first_fit_heap_allocator_tb.sv
